// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/wpcs_pkg.sv -----
`default_nettype none
package wpcs_pkg;

  localparam int TRACE_LEN = 512;
  localparam int ADDR_W = $clog2(TRACE_LEN);
  localparam int POS_W = ($clog2(TRACE_LEN + 2) > 10) ? $clog2(TRACE_LEN + 2) : 10;

  localparam int IDX_FIELD_W = 9;
  localparam int AMP_W = 8;

  localparam int WRAP_RIGHT_TO = 14;
  localparam int WRAP_LEFT_AT = 5;

  localparam logic [AMP_W-1:0] MIN_AMP_RST = 8'd5;
  localparam logic [AMP_W-1:0] MAX_AMP_RST = 8'd200;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AMP = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;
  localparam logic DIR_LEFT = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [IDX_FIELD_W-1:0] sample_index;
    logic [AMP_W-1:0]       sample_value;
    logic [IDX_FIELD_W-1:0] start_pos;
    logic                   direction;
  } wpcs_in_t;

  typedef struct packed {
    logic                   found;
    logic [IDX_FIELD_W-1:0] peak_pos;
    logic [AMP_W-1:0]       peak_amp;
  } wpcs_out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/waveform_peak_cursor_search.sv -----
`default_nettype none
// channel | ports                           | handshake
// --------+---------------------------------+-------------------------------
// input   | start, busy, in_data            | beat taken when start & !busy
// result  | out_strobe, out_data            | beat shown for one cycle
// config  | cfg_we, cfg_index, cfg_wdata    | written when cfg_we is high
//
// A load does not raise busy. A search holds busy through a priming state, the filling of
// the sample window, the examination of each position in turn and a refill of the window
// after each wrap, all set by the single trace memory read port.
// The result beat shows in the cycle after the last position is examined, as busy falls.
// Reset is synchronous, active low, and leaves the trace memory as it is; no stall.
module waveform_peak_cursor_search (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire wpcs_pkg::wpcs_in_t            in_data,
  output logic                               out_strobe,
  output wpcs_pkg::wpcs_out_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [wpcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wpcs_pkg::AMP_W-1:0]    cfg_wdata
);
  import wpcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_PRIME = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TRACE_LEN - 1);
  localparam logic [POS_W-1:0] RIGHT_TO = POS_W'(WRAP_RIGHT_TO);
  localparam logic [POS_W-1:0] LEFT_AT  = POS_W'(WRAP_LEFT_AT);
  localparam logic [POS_W-1:0] LEN_POS  = POS_W'(TRACE_LEN);

  function automatic logic [POS_W:0] step_pos(input logic [POS_W-1:0] p, input logic dir);
    logic [POS_W:0] r;
    if (dir == DIR_RIGHT) begin
      if (p >= LAST_POS) r = {1'b1, RIGHT_TO};
      else r = {1'b0, p + POS_W'(1)};
    end else begin
      if (p <= LEFT_AT + POS_W'(1)) r = {1'b1, LAST_POS};
      else r = {1'b0, p - POS_W'(1)};
    end
    return r;
  endfunction

  logic [AMP_W-1:0] trace_mem [TRACE_LEN];

  state_t           state_r;
  logic [AMP_W-1:0] min_amp_r, max_amp_r;
  logic [POS_W-1:0] fa_r, q_r;
  logic             dir_r;
  logic [1:0]       wraps_r;
  logic [1:0]       cnt_r;
  logic             rv_r, rzero_r;
  logic [AMP_W-1:0] rdata_r;
  logic [AMP_W-1:0] prev_r;
  logic [AMP_W-1:0] win_r [3];
  logic             out_strobe_r;
  wpcs_out_t        out_data_r;

  logic             acc, acc_load, acc_search;
  logic [POS_W-1:0] start_ext, p0, wr_pos, rd_pos;
  logic [POS_W:0]   head_step, eval_step;
  logic             rd_zero, issue, full, peak, done, adv, flush;
  logic [AMP_W-1:0] smp, amp;
  logic [1:0]       slot;

  assign busy       = (state_r != ST_IDLE);
  assign acc        = start && !busy;
  assign acc_load   = acc && (in_data.req_type == REQ_LOAD);
  assign acc_search = acc && (in_data.req_type == REQ_SEARCH);

  assign start_ext = POS_W'(in_data.start_pos);
  assign p0        = (start_ext <= LEFT_AT) ? LAST_POS : start_ext;
  assign head_step = step_pos(p0, in_data.direction);
  assign wr_pos    = POS_W'(in_data.sample_index);

  assign amp  = win_r[0];
  assign full = (state_r == ST_RUN) && (cnt_r == 2'd3);
  assign peak = (amp > min_amp_r) && (amp < max_amp_r) && (amp > prev_r) &&
                (amp >= win_r[1]) && (amp >= win_r[2]);
  assign eval_step = step_pos(q_r, dir_r);
  assign done  = full && (peak || (wraps_r == 2'd2));
  assign adv   = full && !done && !eval_step[POS_W];
  assign flush = full && !done && eval_step[POS_W];
  assign slot  = cnt_r - {1'b0, adv};
  assign smp   = rzero_r ? '0 : rdata_r;

  assign issue   = acc_search || (state_r == ST_PRIME) || ((state_r == ST_RUN) && !flush);
  assign rd_pos  = (state_r == ST_IDLE) ? start_ext : fa_r;
  assign rd_zero = (rd_pos >= LEN_POS);

  always_ff @(posedge clk) begin
    if (acc_load && (wr_pos < LEN_POS)) begin
      trace_mem[wr_pos[ADDR_W-1:0]] <= in_data.sample_value;
    end
    if (issue && !rd_zero) begin
      rdata_r <= trace_mem[rd_pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      min_amp_r    <= MIN_AMP_RST;
      max_amp_r    <= MAX_AMP_RST;
      cnt_r        <= '0;
      rv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_AMP: min_amp_r <= cfg_wdata;
          CFG_MAX_AMP: max_amp_r <= cfg_wdata;
          default: ;
        endcase
      end
      rv_r         <= issue;
      out_strobe_r <= done;
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (acc_search) state_r <= ST_PRIME;
        end
        ST_PRIME: begin
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (done) state_r <= ST_IDLE;
          else if (flush) cnt_r <= '0;
          else cnt_r <= cnt_r - {1'b0, adv} + {1'b0, rv_r};
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rzero_r <= rd_zero;
    if (done) begin
      out_data_r.found    <= peak;
      out_data_r.peak_pos <= peak ? q_r[IDX_FIELD_W-1:0] : '0;
      out_data_r.peak_amp <= peak ? amp : '0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (acc_search) begin
          dir_r   <= in_data.direction;
          q_r     <= head_step[POS_W-1:0];
          fa_r    <= head_step[POS_W-1:0];
          wraps_r <= {1'b0, head_step[POS_W]};
        end
      end
      ST_PRIME: begin
        prev_r <= smp;
        fa_r   <= (dir_r == DIR_RIGHT) ? fa_r + POS_W'(1) : fa_r - POS_W'(1);
      end
      ST_RUN: begin
        if (flush) begin
          prev_r  <= amp;
          q_r     <= eval_step[POS_W-1:0];
          fa_r    <= eval_step[POS_W-1:0];
          wraps_r <= wraps_r + 2'd1;
        end else begin
          fa_r <= (dir_r == DIR_RIGHT) ? fa_r + POS_W'(1) : fa_r - POS_W'(1);
          if (adv) begin
            prev_r   <= amp;
            q_r      <= eval_step[POS_W-1:0];
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
          end
          if (rv_r && !done) win_r[slot] <= smp;
        end
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
`default_nettype wire

// ----- hw/rtl/wpcs_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module wpcs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire wpcs_pkg::wpcs_in_t            in_data,
  input wire logic                          out_strobe,
  input wire wpcs_pkg::wpcs_out_t           out_data
);
  import wpcs_pkg::*;

  `ASSERT_IMP(a_miss_zero, clk, rst_n, out_strobe && !out_data.found, (out_data.peak_pos == '0) && (out_data.peak_amp == '0), "miss beat carries non-zero position or amplitude")
  `ASSERT_IMP(a_hit_amp, clk, rst_n, out_strobe && out_data.found, out_data.peak_amp != '0, "peak beat with zero amplitude")
  `ASSERT_NXT(a_strobe_once, clk, rst_n, out_strobe, !out_strobe, "result beat repeated")
  `ASSERT_NXT(a_search_busy, clk, rst_n, start && !busy && (in_data.req_type == REQ_SEARCH), busy, "search beat taken without going busy")
  `ASSERT_NXT(a_load_idle, clk, rst_n, start && !busy && (in_data.req_type == REQ_LOAD), !busy && !out_strobe, "load beat caused busy or a result")

endmodule

bind waveform_peak_cursor_search wpcs_checker u_wpcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
`default_nettype wire

// ----- verif/testbench.sv -----
module testbench;
  import wpcs_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam logic [AMP_W-1:0] FLAT_LEVEL = 8'd50;
  localparam wpcs_out_t NO_PEAK = '0;

  typedef enum logic [1:0] {ROW_LOAD, ROW_SEARCH, ROW_WINDOW} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [IDX_FIELD_W-1:0] pos;
    logic [AMP_W-1:0]       amp_a;
    logic [AMP_W-1:0]       amp_b;
    logic                   dir;
    logic                   typed;
    wpcs_out_t              want;
  } stim_row_t;

  localparam int N_ROWS = 28;
  localparam stim_row_t SCRIPT [N_ROWS] = '{
    '{ROW_SEARCH, 9'd100, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, NO_PEAK},
    '{ROW_LOAD,   9'd100, 8'd120, 8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd90,  8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd100, 8'd120}},
    '{ROW_SEARCH, 9'd110, 8'd0,   8'd0,   DIR_LEFT,  1'b1, '{1'b1, 9'd100, 8'd120}},
    '{ROW_SEARCH, 9'd3,   8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd100, 8'd120}},
    '{ROW_LOAD,   9'd511, 8'd199, 8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd300, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd511, 8'd199}},
    '{ROW_SEARCH, 9'd0,   8'd0,   8'd0,   DIR_LEFT,  1'b1, '{1'b1, 9'd100, 8'd120}},
    '{ROW_LOAD,   9'd6,   8'd180, 8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd40,  8'd0,   8'd0,   DIR_LEFT,  1'b1, '{1'b1, 9'd6, 8'd180}},
    '{ROW_LOAD,   9'd200, 8'd200, 8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_LOAD,   9'd300, 8'd255, 8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd150, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd511, 8'd199}},
    '{ROW_LOAD,   9'd410, 8'd90,  8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_LOAD,   9'd411, 8'd90,  8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd405, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd410, 8'd90}},
    '{ROW_SEARCH, 9'd415, 8'd0,   8'd0,   DIR_LEFT,  1'b1, '{1'b1, 9'd411, 8'd90}},
    '{ROW_LOAD,   9'd420, 8'd80,  8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_LOAD,   9'd422, 8'd95,  8'd0,   DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd415, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd422, 8'd95}},
    '{ROW_WINDOW, 9'd0,   8'd120, 8'd255, DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd110, 8'd0,   8'd0,   DIR_LEFT,  1'b1, '{1'b1, 9'd6, 8'd180}},
    '{ROW_SEARCH, 9'd150, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd200, 8'd200}},
    '{ROW_WINDOW, 9'd0,   8'd255, 8'd255, DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd511, 8'd0,   8'd0,   DIR_LEFT,  1'b1, NO_PEAK},
    '{ROW_WINDOW, 9'd0,   8'd0,   8'd255, DIR_RIGHT, 1'b0, NO_PEAK},
    '{ROW_SEARCH, 9'd250, 8'd0,   8'd0,   DIR_RIGHT, 1'b1, '{1'b1, 9'd410, 8'd90}},
    '{ROW_SEARCH, 9'd13,  8'd0,   8'd0,   DIR_RIGHT, 1'b0, NO_PEAK}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  wpcs_in_t               in_data;
  logic                   out_strobe;
  wpcs_out_t              out_data;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [AMP_W-1:0]       cfg_wdata;

  logic [AMP_W-1:0] trace_copy [TRACE_LEN];
  logic [AMP_W-1:0] amp_floor = MIN_AMP_RST;
  logic [AMP_W-1:0] amp_ceiling = MAX_AMP_RST;
  wpcs_out_t        pending_peaks [$];
  wpcs_out_t        oldest_peak;

  int mismatches = 0;
  int load_count = 0;
  int search_count = 0;
  int found_count = 0;
  int window_count = 0;

  waveform_peak_cursor_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [AMP_W-1:0] sample_at(input int i);
    return (i < TRACE_LEN) ? trace_copy[i] : '0;
  endfunction

  function automatic bit qualifies(input logic [AMP_W-1:0] amp, input logic [AMP_W-1:0] prior,
                                   input logic [AMP_W-1:0] n1, input logic [AMP_W-1:0] n2);
    if (amp <= amp_floor || amp >= amp_ceiling) return 1'b0;
    return (amp > prior) && (amp >= n1) && (amp >= n2);
  endfunction

  function automatic wpcs_out_t find_peak(input logic [IDX_FIELD_W-1:0] from, input logic dir);
    int               p;
    int               wraps;
    bit               hit;
    logic [AMP_W-1:0] amp;
    logic [AMP_W-1:0] prior;
    wpcs_out_t        r;
    p = from;
    amp = sample_at(p);
    if (p <= WRAP_LEFT_AT) p = TRACE_LEN - 1;
    wraps = 0;
    hit = 1'b0;
    while (wraps <= 1 && !hit) begin
      prior = amp;
      if (dir == DIR_RIGHT) begin
        p++;
        if (p >= TRACE_LEN) begin
          p = WRAP_RIGHT_TO;
          wraps++;
        end
        amp = sample_at(p);
        hit = qualifies(amp, prior, sample_at(p + 1), sample_at(p + 2));
      end else begin
        p--;
        if (p <= WRAP_LEFT_AT) begin
          p = TRACE_LEN - 1;
          wraps++;
        end
        amp = sample_at(p);
        hit = qualifies(amp, prior, sample_at(p - 1), sample_at(p - 2));
      end
    end
    r = NO_PEAK;
    if (hit) begin
      r.found = 1'b1;
      r.peak_pos = p[IDX_FIELD_W-1:0];
      r.peak_amp = amp;
    end
    return r;
  endfunction

  function automatic wpcs_in_t noise_beat();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(wpcs_in_t)-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // hold start high across back-to-back beats; drop it only for an idle burst
  task automatic issue(input wpcs_in_t beat, input bit typed, input wpcs_out_t want,
                       input bit may_idle);
    if (may_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_data <= beat;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (beat.req_type == REQ_LOAD) begin
      trace_copy[beat.sample_index] = beat.sample_value;
      load_count++;
    end else begin
      pending_peaks.push_back(typed ? want : find_peak(beat.start_pos, beat.direction));
      search_count++;
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_peaks.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [AMP_W-1:0] lo, input logic [AMP_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_AMP;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_MAX_AMP;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    amp_floor = lo;
    amp_ceiling = hi;
    window_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (out_data.found) found_count++;
      if (pending_peaks.size() == 0) begin
        report_mismatch($sformatf("result with no search pending: found %0d pos %0d amp %0d",
                                  out_data.found, out_data.peak_pos, out_data.peak_amp));
      end else begin
        oldest_peak = pending_peaks.pop_front();
        if (out_data.found !== oldest_peak.found)
          report_mismatch($sformatf("found %0d, expected %0d", out_data.found,
                                    oldest_peak.found));
        if (out_data.peak_pos !== oldest_peak.peak_pos)
          report_mismatch($sformatf("peak_pos %0d, expected %0d", out_data.peak_pos,
                                    oldest_peak.peak_pos));
        if (out_data.peak_amp !== oldest_peak.peak_amp)
          report_mismatch($sformatf("peak_amp %0d, expected %0d", out_data.peak_amp,
                                    oldest_peak.peak_amp));
      end
    end
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("timeout with %0d results pending", pending_peaks.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    stim_row_t        row;
    wpcs_in_t         beat;
    logic [AMP_W-1:0] base;
    int               made;
    int               hunts;
    int               pick;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_AMP;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // fill every entry so no search can reach an unwritten sample
    for (int i = 0; i < TRACE_LEN; i++) begin
      beat = noise_beat();
      beat.req_type = REQ_LOAD;
      beat.sample_index = i[IDX_FIELD_W-1:0];
      beat.sample_value = FLAT_LEVEL;
      issue(beat, 1'b0, NO_PEAK, 1'b1);
    end

    for (int r = 0; r < N_ROWS; r++) begin
      row = SCRIPT[r];
      case (row.kind)
        ROW_LOAD: begin
          beat = noise_beat();
          beat.req_type = REQ_LOAD;
          beat.sample_index = row.pos;
          beat.sample_value = row.amp_a;
          issue(beat, 1'b0, NO_PEAK, 1'b1);
        end
        ROW_SEARCH: begin
          beat = noise_beat();
          beat.req_type = REQ_SEARCH;
          beat.start_pos = row.pos;
          beat.direction = row.dir;
          issue(beat, row.typed, row.want, 1'b1);
        end
        default: begin
          settle();
          write_window(row.amp_a, row.amp_b);
        end
      endcase
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: write_window(MIN_AMP_RST, MAX_AMP_RST);
        1: write_window(8'd0, 8'd255);
        2: write_window(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: write_window(8'd40, 8'd230);
      endcase
      base = 8'($urandom_range(20, 120));
      made = 0;
      hunts = 0;
      while (made < 10 || hunts < 4) begin
        beat = noise_beat();
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 6) begin
          beat.req_type = REQ_LOAD;
          if (pick < 5) beat.sample_value = base;
          else if (pick < 8) beat.sample_value = base + 8'($urandom_range(1, 60));
        end else begin
          beat.req_type = REQ_SEARCH;
          if (pick < 2) beat.start_pos = 9'($urandom_range(0, WRAP_LEFT_AT));
          else if (pick == 2) beat.start_pos = 9'(TRACE_LEN - 1);
          hunts++;
        end
        issue(beat, 1'b0, NO_PEAK, ph != 3);
        made++;
        if (ph != 3 && $urandom_range(0, 24) == 0) settle();
      end
    end

    settle();
    repeat (1100) @(posedge clk);
    $display("covered %0d sample loads and %0d cursor searches, %0d of them landing on a peak",
             load_count, search_count, found_count);
    $display("amplitude window rewritten %0d times across a %0d-row directed script",
             window_count, N_ROWS);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
